/* rtl/adaptive_arith_encoder_order_n_assert.svh */
// Assertion macros for the adaptive arithmetic encoder.
// Used by the top level; needs nothing else.
`ifndef ADAPTIVE_ARITH_ENCODER_ORDER_N_ASSERT_SVH
`define ADAPTIVE_ARITH_ENCODER_ORDER_N_ASSERT_SVH

// same-cycle implication
`define AAE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aae assertion failed");

// next-cycle implication
`define AAE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aae assertion failed");

`endif

/* rtl/aae_pkg.sv */
// Shared types and constants of the adaptive arithmetic encoder.
// No dependencies.
`default_nettype none
package aae_pkg;
   localparam int CODE_BITS = 16;
   localparam int PROD_W    = 32;
   localparam int RSP_DATA_W = 24;

   localparam logic [1:0] KIND_ENCODE  = 2'd0;
   localparam logic [1:0] KIND_FLUSH   = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   localparam logic [1:0] REG_ALPHABET = 2'd0;
   localparam logic [1:0] REG_ORDER    = 2'd1;
   localparam logic [1:0] REG_LIMIT    = 2'd2;

   typedef struct packed {
      logic                  start;
      logic [PROD_W-1:0]     dividend;
      logic [CODE_BITS-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [PROD_W-1:0]     quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

/* rtl/aae_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on aae_pkg.
`default_nettype none
module aae_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire aae_pkg::div_req_type div_req,
   output      aae_pkg::div_rsp_type div_rsp
);
   localparam int CNT_W = $clog2(aae_pkg::PROD_W + 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [aae_pkg::CODE_BITS-1:0] rem_ff, rem_in;
   logic [aae_pkg::CODE_BITS-1:0] dsr_ff, dsr_in;
   logic [aae_pkg::PROD_W-1:0]    quo_ff, quo_in;
   logic [aae_pkg::CODE_BITS:0]   trial;
   logic [aae_pkg::CODE_BITS:0]   diff;
   logic                          ge;

   assign trial = {rem_ff, quo_ff[aae_pkg::PROD_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign ge    = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(aae_pkg::PROD_W);
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[aae_pkg::CODE_BITS-1:0] : trial[aae_pkg::CODE_BITS-1:0];
         quo_in = {quo_ff[aae_pkg::PROD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule
`default_nettype wire

/* rtl/adaptive_arith_encoder_order_n.sv */
// Adaptive order-n arithmetic encoder, 16-bit code registers.
// Channels: req_ (input items), rsp_ (result items, one per code bit), csr_ (register writes).
// req_tuser = kind, req_tdata[3:0] = symbol. Each item gives one or more rsp transactions,
// the final one flagged by rsp_tlast.
// Per symbol: accept, context walk, three table entries read (the upper one twice), two
// divisions from one shared divider (multiply, start and wait each), renormalization
// steps (up to 16), the last result, then when the model adapts a read and a write per
// bumped entry, and when the total passes the limit a halving walk that reads entry 0
// and then reads and writes each further entry.
// Flush: 16 bits. The serial divider and the single table port set the pace.
// Reset, restart items and writes to alphabet_size or model_order start a clearing pass over
// all DEPTH entries (4352 at default parameters) of the count memory; no item is accepted then,
// a restart returns its result after the pass. Register writes are always taken.
// A result waits in an output register; a stalled receiver holds the encoder at its next
// result, and the last result of an item does not keep the next item from being accepted.
`default_nettype none
module adaptive_arith_encoder_order_n #(
   parameter int MAX_SYMBOLS = 16,
   parameter int MAX_ORDER   = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [3:0] symbol
   input  wire logic [1:0]  req_tuser,   // [1:0] kind
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] code_bit, [16:1] opposite_count, [19:17] pad_zeros
   output      logic [aae_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output      logic [1:0]  rsp_tuser,   // [0] has_bit, [1] bad_symbol
   output      logic        rsp_tlast,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [13:0] csr_data
);
   `include "adaptive_arith_encoder_order_n_assert.svh"

   localparam int CB        = aae_pkg::CODE_BITS;
   localparam int CTX_COUNT = MAX_SYMBOLS ** MAX_ORDER;
   localparam int DEPTH     = CTX_COUNT * (MAX_SYMBOLS + 1);
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int SYM_W     = $clog2(MAX_SYMBOLS + 1);
   localparam int CNT_W     = $clog2(MAX_ORDER + 2);
   localparam int CTX_SLOTS = (MAX_ORDER > 0) ? MAX_ORDER : 1;
   localparam int SLOT_W    = (CTX_SLOTS > 1) ? $clog2(CTX_SLOTS) : 1;
   localparam int K_W       = $clog2(CB + 1);
   localparam logic [CB-1:0] TOP = {CB{1'b1}};

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_CLEAR   = 5'd1;
   localparam logic [4:0] S_CTX     = 5'd2;
   localparam logic [4:0] S_RD0     = 5'd3;
   localparam logic [4:0] S_RD1     = 5'd4;
   localparam logic [4:0] S_RD2     = 5'd5;
   localparam logic [4:0] S_RD3     = 5'd6;
   localparam logic [4:0] S_MULH    = 5'd7;
   localparam logic [4:0] S_DIVHGO  = 5'd8;
   localparam logic [4:0] S_DIVH    = 5'd9;
   localparam logic [4:0] S_MULL    = 5'd10;
   localparam logic [4:0] S_DIVLGO  = 5'd11;
   localparam logic [4:0] S_DIVL    = 5'd12;
   localparam logic [4:0] S_RENORM  = 5'd13;
   localparam logic [4:0] S_FINAL   = 5'd14;
   localparam logic [4:0] S_BUMPRD  = 5'd15;
   localparam logic [4:0] S_BUMPWR  = 5'd16;
   localparam logic [4:0] S_HALFRD0 = 5'd17;
   localparam logic [4:0] S_HALFP0  = 5'd18;
   localparam logic [4:0] S_HALFRD  = 5'd19;
   localparam logic [4:0] S_HALFWR  = 5'd20;

   logic [4:0]        state_ff, state_in;
   logic [4:0]        alph_ff, alph_in;
   logic [1:0]        order_ff, order_in;
   logic [13:0]       limit_ff, limit_in;
   logic [CB-1:0]     low_ff, low_in, high_ff, high_in, pend_ff, pend_in;
   logic [2:0]        phase_ff, phase_in;
   logic [3:0]        recent_ff [CTX_SLOTS];
   logic [3:0]        recent_in [CTX_SLOTS];
   logic [1:0]        kind_ff, kind_in;
   logic [3:0]        sym_ff, sym_in;
   logic              bad_ff, bad_in;
   logic              clr_item_ff, clr_item_in;
   logic [ADDR_W-1:0] caddr_ff, caddr_in;
   logic [SYM_W-1:0]  mod_ff, mod_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] acc_ff, acc_in, base_ff, base_in;
   logic [CB-1:0]     scale_ff, scale_in, lc_ff, lc_in, qh_ff, qh_in;
   logic [aae_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic              hold_vld_ff, hold_vld_in, hold_bit_ff, hold_bit_in;
   logic [CB-1:0]     hold_opp_ff, hold_opp_in;
   logic [SYM_W-1:0]  idx_ff, idx_in;
   logic [CB-1:0]     prev_ff, prev_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [aae_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]        rsp_user_ff, rsp_user_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [CB-1:0]     mem [DEPTH];
   logic [CB-1:0]     rd_data_ff;
   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we;
   logic [CB-1:0]     mem_wdata;

   aae_pkg::div_req_type div_req;
   aae_pkg::div_rsp_type div_rsp;

   logic [SYM_W-1:0]  m_eff;
   logic [CNT_W-1:0]  ord_eff;
   logic              out_free;
   logic              e12, e3;
   logic [CB:0]       rng;
   logic [CB-1:0]     low_and, high_or, half_v, bump_v;
   logic [ADDR_W-1:0] sym_a;

   assign m_eff = (alph_ff < 5'd2) ? SYM_W'(2) :
                  ((32'(alph_ff) > MAX_SYMBOLS) ? SYM_W'(MAX_SYMBOLS) : SYM_W'(alph_ff));
   assign ord_eff = (32'(order_ff) > MAX_ORDER) ? CNT_W'(MAX_ORDER) : CNT_W'(order_ff);
   assign out_free = !rsp_vld_ff || rsp_tready;
   assign e12 = ~(low_ff[CB-1] ^ high_ff[CB-1]);
   assign e3  = low_ff[CB-2] & ~high_ff[CB-2];
   assign rng = {1'b0, high_ff} - {1'b0, low_ff} + 1'b1;
   assign low_and = low_ff & {2'b00, {(CB-2){1'b1}}};
   assign high_or = high_ff | {2'b01, {(CB-2){1'b0}}};
   assign sym_a = ADDR_W'(sym_ff);
   assign bump_v = rd_data_ff + 1'b1;
   assign half_v = ({1'b0, rd_data_ff[CB-1:1]} <= prev_ff) ? prev_ff + 1'b1
                                                           : {1'b0, rd_data_ff[CB-1:1]};

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // table port address and write
   always_comb begin
      mem_addr  = base_ff;
      mem_we    = 1'b0;
      mem_wdata = bump_v;
      case (state_ff)
         S_CLEAR: begin
            mem_addr  = caddr_ff;
            mem_we    = 1'b1;
            mem_wdata = CB'(mod_ff);
         end
         S_RD0:    mem_addr = base_ff + ADDR_W'(m_eff);
         S_RD1:    mem_addr = base_ff + sym_a;
         S_RD2:    mem_addr = base_ff + sym_a + 1'b1;
         // read again so the upper count is still on the port in S_MULH
         S_RD3:    mem_addr = base_ff + sym_a + 1'b1;
         S_BUMPRD: mem_addr = base_ff + ADDR_W'(idx_ff);
         S_BUMPWR: begin
            mem_addr = base_ff + ADDR_W'(idx_ff);
            mem_we   = 1'b1;
         end
         S_HALFRD: mem_addr = base_ff + ADDR_W'(idx_ff);
         S_HALFWR: begin
            mem_addr  = base_ff + ADDR_W'(idx_ff);
            mem_we    = 1'b1;
            mem_wdata = half_v;
         end
         default: mem_addr = base_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_addr] <= mem_wdata;
      rd_data_ff <= mem[mem_addr];
   end

   always_comb begin
      div_req.start    = (state_ff == S_DIVHGO) || (state_ff == S_DIVLGO);
      div_req.dividend = prod_ff;
      div_req.divisor  = (scale_ff == '0) ? CB'(1) : scale_ff;
   end

   aae_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in    = state_ff;
      alph_in     = alph_ff;
      order_in    = order_ff;
      limit_in    = limit_ff;
      low_in      = low_ff;
      high_in     = high_ff;
      pend_in     = pend_ff;
      phase_in    = phase_ff;
      recent_in   = recent_ff;
      kind_in     = kind_ff;
      sym_in      = sym_ff;
      bad_in      = bad_ff;
      clr_item_in = clr_item_ff;
      caddr_in    = caddr_ff;
      mod_in      = mod_ff;
      cnt_in      = cnt_ff;
      acc_in      = acc_ff;
      base_in     = base_ff;
      scale_in    = scale_ff;
      lc_in       = lc_ff;
      qh_in       = qh_ff;
      prod_in     = prod_ff;
      k_in        = k_ff;
      hold_vld_in = hold_vld_ff;
      hold_bit_in = hold_bit_ff;
      hold_opp_in = hold_opp_ff;
      idx_in      = idx_ff;
      prev_in     = prev_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_last_in = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in     = req_tuser;
               sym_in      = req_tdata[3:0];
               bad_in      = 1'b0;
               hold_vld_in = 1'b0;
               case (req_tuser)
                  aae_pkg::KIND_ENCODE: begin
                     if (32'(req_tdata[3:0]) >= 32'(m_eff)) begin
                        bad_in   = 1'b1;
                        state_in = S_FINAL;
                     end else begin
                        cnt_in   = ord_eff;
                        acc_in   = '0;
                        state_in = S_CTX;
                     end
                  end
                  aae_pkg::KIND_FLUSH: begin
                     low_in   = high_ff;
                     k_in     = '0;
                     state_in = S_RENORM;
                  end
                  aae_pkg::KIND_RESTART: begin
                     low_in      = '0;
                     high_in     = TOP;
                     pend_in     = '0;
                     phase_in    = '0;
                     for (int i = 0; i < CTX_SLOTS; i++)
                        recent_in[i] = '0;
                     caddr_in    = '0;
                     mod_in      = '0;
                     clr_item_in = 1'b1;
                     state_in    = S_CLEAR;
                  end
                  default: state_in = S_FINAL;
               endcase
            end
         end
         S_CLEAR: begin
            caddr_in = caddr_ff + 1'b1;
            mod_in   = (mod_ff == m_eff) ? '0 : mod_ff + 1'b1;
            if (32'(caddr_ff) == DEPTH - 1) begin
               state_in    = clr_item_ff ? S_FINAL : S_IDLE;
               clr_item_in = 1'b0;
            end
         end
         S_CTX: begin
            // Horner over the previous symbols, newest weight highest
            if (cnt_ff != '0) begin
               acc_in = ADDR_W'(acc_ff * m_eff) +
                        ADDR_W'(recent_ff[SLOT_W'(cnt_ff - 1'b1)]);
               cnt_in = cnt_ff - 1'b1;
            end else begin
               base_in = ADDR_W'(acc_ff * m_eff) + acc_ff;
               for (int i = 0; i < CTX_SLOTS; i++) begin
                  if (i + 1 < CTX_SLOTS && 32'(i + 1) < 32'(ord_eff))
                     recent_in[i] = recent_ff[(i + 1) % CTX_SLOTS];
                  else if (32'(i + 1) == 32'(ord_eff))
                     recent_in[i] = sym_ff;
               end
               state_in = S_RD0;
            end
         end
         S_RD0: state_in = S_RD1;
         S_RD1: begin
            scale_in = rd_data_ff;
            state_in = S_RD2;
         end
         S_RD2: begin
            lc_in    = rd_data_ff;
            state_in = S_RD3;
         end
         S_RD3: state_in = S_MULH;
         S_MULH: begin
            prod_in  = aae_pkg::PROD_W'(32'(rng) * 32'(rd_data_ff));
            state_in = S_DIVHGO;
         end
         S_DIVHGO: state_in = S_DIVH;
         S_DIVH: begin
            if (div_rsp.done) begin
               qh_in    = div_rsp.quotient[CB-1:0];
               state_in = S_MULL;
            end
         end
         S_MULL: begin
            prod_in  = aae_pkg::PROD_W'(32'(rng) * 32'(lc_ff));
            state_in = S_DIVLGO;
         end
         S_DIVLGO: state_in = S_DIVL;
         S_DIVL: begin
            if (div_rsp.done) begin
               high_in  = low_ff + qh_ff - 1'b1;
               low_in   = low_ff + div_rsp.quotient[CB-1:0];
               k_in     = '0;
               state_in = S_RENORM;
            end
         end
         S_RENORM: begin
            if (32'(k_ff) == CB || (!e12 && !e3)) begin
               state_in = S_FINAL;
            end else if (e12) begin
               // previous bit goes out once it is known not to be the last
               if (!hold_vld_ff || out_free) begin
                  if (hold_vld_ff) begin
                     rsp_vld_in  = 1'b1;
                     rsp_data_in = {4'b0, 3'b0, hold_opp_ff, hold_bit_ff};
                     rsp_user_in = 2'b01;
                     rsp_last_in = 1'b0;
                  end
                  hold_vld_in = 1'b1;
                  hold_bit_in = high_ff[CB-1];
                  hold_opp_in = pend_ff;
                  pend_in     = '0;
                  phase_in    = phase_ff + 3'd1 + pend_ff[2:0];
                  low_in      = {low_ff[CB-2:0], 1'b0};
                  high_in     = {high_ff[CB-2:0], 1'b1};
                  k_in        = k_ff + 1'b1;
               end
            end else begin
               if (pend_ff != TOP)
                  pend_in = pend_ff + 1'b1;
               low_in  = {low_and[CB-2:0], 1'b0};
               high_in = {high_or[CB-2:0], 1'b1};
               k_in    = k_ff + 1'b1;
            end
         end
         S_FINAL: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_last_in = 1'b1;
               rsp_data_in = {4'b0, (kind_ff == aae_pkg::KIND_FLUSH) ? 3'd0 - phase_ff : 3'd0,
                              hold_vld_ff ? hold_opp_ff : '0, hold_vld_ff & hold_bit_ff};
               rsp_user_in = {bad_ff, hold_vld_ff};
               hold_vld_in = 1'b0;
               if (kind_ff == aae_pkg::KIND_FLUSH)
                  phase_in = '0;
               if (kind_ff == aae_pkg::KIND_ENCODE && !bad_ff && limit_ff != '0) begin
                  idx_in   = SYM_W'(sym_ff) + 1'b1;
                  state_in = S_BUMPRD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_BUMPRD: state_in = S_BUMPWR;
         S_BUMPWR: begin
            if (idx_ff == m_eff) begin
               idx_in   = SYM_W'(1);
               state_in = (bump_v > CB'(limit_ff)) ? S_HALFRD0 : S_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_BUMPRD;
            end
         end
         S_HALFRD0: state_in = S_HALFP0;
         S_HALFP0: begin
            prev_in  = rd_data_ff;
            state_in = S_HALFRD;
         end
         S_HALFRD: state_in = S_HALFWR;
         S_HALFWR: begin
            prev_in = half_v;
            if (idx_ff == m_eff) begin
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_HALFRD;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_valid) begin
         case (csr_index)
            aae_pkg::REG_ALPHABET: alph_in  = csr_data[4:0];
            aae_pkg::REG_ORDER:    order_in = csr_data[1:0];
            aae_pkg::REG_LIMIT:    limit_in = csr_data;
            default: limit_in = limit_ff;
         endcase
         if (csr_index == aae_pkg::REG_ALPHABET || csr_index == aae_pkg::REG_ORDER) begin
            for (int i = 0; i < CTX_SLOTS; i++)
               recent_in[i] = '0;
            caddr_in    = '0;
            mod_in      = '0;
            clr_item_in = 1'b0;
            state_in    = S_CLEAR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         alph_ff     <= 5'd2;
         order_ff    <= '0;
         limit_ff    <= '0;
         low_ff      <= '0;
         high_ff     <= TOP;
         pend_ff     <= '0;
         phase_ff    <= '0;
         for (int i = 0; i < CTX_SLOTS; i++)
            recent_ff[i] <= '0;
         clr_item_ff <= 1'b0;
         caddr_ff    <= '0;
         mod_ff      <= '0;
         hold_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         alph_ff     <= alph_in;
         order_ff    <= order_in;
         limit_ff    <= limit_in;
         low_ff      <= low_in;
         high_ff     <= high_in;
         pend_ff     <= pend_in;
         phase_ff    <= phase_in;
         recent_ff   <= recent_in;
         clr_item_ff <= clr_item_in;
         caddr_ff    <= caddr_in;
         mod_ff      <= mod_in;
         hold_vld_ff <= hold_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      kind_ff     <= kind_in;
      sym_ff      <= sym_in;
      bad_ff      <= bad_in;
      cnt_ff      <= cnt_in;
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      scale_ff    <= scale_in;
      lc_ff       <= lc_in;
      qh_ff       <= qh_in;
      prod_ff     <= prod_in;
      k_ff        <= k_in;
      hold_bit_ff <= hold_bit_in;
      hold_opp_ff <= hold_opp_in;
      idx_ff      <= idx_in;
      prev_ff     <= prev_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   `AAE_ASSERT_NOW(a_div_done_when_waiting, clock, reset, div_rsp.done,
      state_ff == S_DIVH || state_ff == S_DIVL)
   `AAE_ASSERT_NEXT(a_final_loads_output, clock, reset, state_ff == S_FINAL && out_free,
      rsp_vld_ff && rsp_last_ff)
   `AAE_ASSERT_NOW(a_flush_closes_interval, clock, reset,
      state_ff == S_FINAL && kind_ff == aae_pkg::KIND_FLUSH,
      low_ff == '0 && high_ff == TOP && pend_ff == '0)
endmodule
`default_nettype wire

/* tb/tb_adaptive_arith_encoder_order_n.sv */
// Self-checking testbench for the adaptive order-n arithmetic encoder.
// Needs aae_pkg and adaptive_arith_encoder_order_n; a scoreboard class tracks the
// encoder state and the queue of expected code-bit transactions.
`default_nettype none
module tb_adaptive_arith_encoder_order_n;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int DEPTH     = 4352;
   localparam int SETTLE    = 400;

   typedef struct packed {
      logic        has_bit;
      logic        code_bit;
      logic [15:0] opp;
      logic [2:0]  pad;
      logic        bad;
      logic        last;
   } code_rsp_type;

   class code_scoreboard;
      int unsigned alpha_reg, order_reg, limit_reg;
      int unsigned low, high, pending, phase;
      int unsigned hist [2];
      logic [15:0] counts [DEPTH];
      code_rsp_type expected_q [$];

      function int unsigned symbols();
         return (alpha_reg < 2) ? 2 : (alpha_reg > 16) ? 16 : alpha_reg;
      endfunction

      function int unsigned depth_used();
         return (order_reg > 2) ? 2 : order_reg;
      endfunction

      function void init_tables();
         int unsigned m1;
         m1 = symbols() + 1;
         for (int j = 0; j < DEPTH; j++) counts[j] = 16'(j % m1);
         hist[0] = 0;
         hist[1] = 0;
      endfunction

      function void init_coder();
         low = 0;
         high = 16'hffff;
         pending = 0;
         phase = 0;
      endfunction

      function new();
         alpha_reg = 2;
         order_reg = 0;
         limit_reg = 0;
         init_coder();
         init_tables();
      endfunction

      function void write_reg(logic [1:0] idx, logic [13:0] val);
         if (idx == aae_pkg::REG_ALPHABET) begin
            alpha_reg = 32'(val[4:0]);
            init_tables();
         end else if (idx == aae_pkg::REG_ORDER) begin
            order_reg = 32'(val[1:0]);
            init_tables();
         end else if (idx == aae_pkg::REG_LIMIT) begin
            limit_reg = 32'(val);
         end
      endfunction

      function void push_bit(int unsigned b, int unsigned o);
         code_rsp_type r;
         r = '0;
         r.has_bit = 1'b1;
         r.code_bit = b[0];
         r.opp = o[15:0];
         expected_q.push_back(r);
         phase = (phase + 1 + (o & 7)) & 7;
      endfunction

      function void push_empty(logic bad);
         code_rsp_type r;
         r = '0;
         r.bad = bad;
         expected_q.push_back(r);
      endfunction

      function void shift_out();
         for (int k = 0; k < 16; k++) begin
            if (((low ^ high) & 16'h8000) == 0) begin
               push_bit((high >> 15) & 1, pending);
               pending = 0;
            end else if ((low & 16'h4000) != 0 && (high & 16'h4000) == 0) begin
               if (pending < 16'hffff) pending++;
               low = low & 16'h3fff;
               high = high | 16'h4000;
            end else begin
               break;
            end
            low = (low << 1) & 16'hffff;
            high = ((high << 1) | 1) & 16'hffff;
         end
      endfunction

      function void code_symbol(int unsigned sym);
         int unsigned m, ord, base, pw, scale, lc, hc, range, v;
         m = symbols();
         ord = depth_used();
         base = 0;
         pw = 1;
         for (int i = 0; i < ord; i++) begin
            base += hist[i] * pw;
            pw *= m;
         end
         base *= (m + 1);
         if (base + m >= DEPTH) base = 0;
         if (ord == 2) hist[0] = hist[1];
         if (ord > 0) hist[ord-1] = sym;
         scale = counts[base+m];
         lc = counts[base+sym];
         hc = counts[base+sym+1];
         if (scale == 0) scale = 1;
         range = (high - low) + 1;
         high = (low + (range * hc) / scale - 1) & 16'hffff;
         low = (low + (range * lc) / scale) & 16'hffff;
         shift_out();
         if (limit_reg > 0) begin
            for (int unsigned i = sym + 1; i <= m; i++)
               counts[base+i] = 16'(counts[base+i] + 1);
            if (counts[base+m] > limit_reg) begin
               for (int unsigned i = 1; i <= m; i++) begin
                  v = counts[base+i] >> 1;
                  if (v <= counts[base+i-1]) v = counts[base+i-1] + 1;
                  counts[base+i] = v[15:0];
               end
            end
         end
      endfunction

      // One accepted input transaction: append everything it must produce.
      function void note_item(logic [1:0] kind, logic [3:0] sym);
         int n0;
         n0 = expected_q.size();
         if (kind == aae_pkg::KIND_ENCODE) begin
            if (sym >= symbols()) push_empty(1'b1);
            else begin
               code_symbol(sym);
               if (expected_q.size() == n0) push_empty(1'b0);
            end
         end else if (kind == aae_pkg::KIND_FLUSH) begin
            low = high;
            shift_out();
            if (expected_q.size() == n0) push_empty(1'b0);
            expected_q[$].pad = 3'((8 - phase) & 7);
            phase = 0;
         end else if (kind == aae_pkg::KIND_RESTART) begin
            init_coder();
            init_tables();
            push_empty(1'b0);
         end else begin
            push_empty(1'b0);
         end
         expected_q[$].last = 1'b1;
      endfunction

      // Returns an empty string on a match, otherwise a description.
      function string check_result(code_rsp_type got);
         code_rsp_type e;
         string s;
         if (expected_q.size() == 0) return $sformatf("unexpected result %p", got);
         e = expected_q.pop_front();
         s = "";
         if (got.has_bit !== e.has_bit)
            s = {s, $sformatf(" has_bit %b/%b", got.has_bit, e.has_bit)};
         if (got.code_bit !== e.code_bit)
            s = {s, $sformatf(" bit %b/%b", got.code_bit, e.code_bit)};
         if (got.opp !== e.opp) s = {s, $sformatf(" opp %0d/%0d", got.opp, e.opp)};
         if (got.pad !== e.pad) s = {s, $sformatf(" pad %0d/%0d", got.pad, e.pad)};
         if (got.bad !== e.bad) s = {s, $sformatf(" bad %b/%b", got.bad, e.bad)};
         if (got.last !== e.last) s = {s, $sformatf(" last %b/%b", got.last, e.last)};
         return s;
      endfunction

      function int waiting();
         return expected_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [3:0] symbol
   logic [1:0]  req_tuser = '0;   // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [0] code_bit, [16:1] opposite_count, [19:17] pad_zeros
   logic [1:0]  rsp_tuser;        // [0] has_bit, [1] bad_symbol
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [13:0] csr_data = '0;

   adaptive_arith_encoder_order_n dut (.*);

   code_scoreboard sb = new();
   int  errors = 0;
   int  items_sent = 0;
   int  bits_seen = 0;
   int  hold_cycles = 0;
   bit  tx_gaps = 1'b1;
   bit  rx_gaps = 1'b1;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t:%s", $realtime, msg);
   endtask

   // Result side: check every accepted transaction, then choose next tready.
   initial begin
      code_rsp_type got;
      string msg;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.has_bit = rsp_tuser[0];
            got.bad = rsp_tuser[1];
            got.code_bit = rsp_tdata[0];
            got.opp = rsp_tdata[16:1];
            got.pad = rsp_tdata[19:17];
            got.last = rsp_tlast;
            if (got.has_bit) bits_seen++;
            msg = sb.check_result(got);
            if (msg != "") report_mismatch(msg);
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(rx_gaps && $urandom_range(99) < 33);
         end
      end
   end

   task automatic send_item(logic [1:0] kind, logic [3:0] sym);
      while (tx_gaps && $urandom_range(99) < 33) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'b0, sym};
      do @(posedge clock); while (!req_tready);
      sb.note_item(kind, sym);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.waiting() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [13:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(idx, val);
   endtask

   task automatic random_items(int count);
      int unsigned p;
      for (int i = 0; i < count; i++) begin
         p = $urandom_range(99);
         if (p < 82)
            send_item(aae_pkg::KIND_ENCODE, 4'($urandom_range(sb.symbols() - 1)));
         else if (p < 87) send_item(aae_pkg::KIND_ENCODE, 4'($urandom_range(15)));
         else if (p < 94) send_item(aae_pkg::KIND_FLUSH, 4'($urandom_range(15)));
         else if (p < 97) send_item(aae_pkg::KIND_RESTART, 4'($urandom_range(15)));
         else send_item(KIND_UNUSED, 4'($urandom_range(15)));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset config: two symbols, order 0, static model
      send_item(aae_pkg::KIND_ENCODE, 4'd0);
      send_item(aae_pkg::KIND_ENCODE, 4'd1);
      send_item(aae_pkg::KIND_ENCODE, 4'd2);      // bad symbol
      send_item(aae_pkg::KIND_ENCODE, 4'd15);     // bad symbol
      send_item(KIND_UNUSED, 4'd0);
      send_item(aae_pkg::KIND_FLUSH, 4'd0);
      send_item(aae_pkg::KIND_FLUSH, 4'd0);       // flush right after flush
      send_item(aae_pkg::KIND_ENCODE, 4'd1);
      send_item(aae_pkg::KIND_RESTART, 4'd0);
      write_reg(aae_pkg::REG_ALPHABET, 14'd16);
      write_reg(aae_pkg::REG_ORDER, 14'd2);
      write_reg(aae_pkg::REG_LIMIT, 14'd16383);
      send_item(aae_pkg::KIND_ENCODE, 4'd15);
      send_item(aae_pkg::KIND_ENCODE, 4'd0);
      send_item(aae_pkg::KIND_ENCODE, 4'd15);
      send_item(aae_pkg::KIND_ENCODE, 4'd15);
      send_item(aae_pkg::KIND_FLUSH, 4'd15);
      for (int i = 0; i < 6; i++) send_item(aae_pkg::KIND_ENCODE, 4'd15);
      send_item(aae_pkg::KIND_FLUSH, 4'd0);
      random_items(40);

      // long receiver hold-off while the sender keeps offering
      drain();
      tx_gaps = 1'b0;
      hold_cycles = 2000;
      random_items(20);
      tx_gaps = 1'b1;

      // out-of-range values are clamped by the block
      write_reg(aae_pkg::REG_ALPHABET, 14'd31);
      write_reg(aae_pkg::REG_ORDER, 14'd3);
      write_reg(aae_pkg::REG_LIMIT, 14'd1);
      random_items(40);

      write_reg(aae_pkg::REG_ALPHABET, 14'd5);
      write_reg(aae_pkg::REG_ORDER, 14'd1);
      write_reg(aae_pkg::REG_LIMIT, 14'd30);
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      random_items(50);
      tx_gaps = 1'b1;
      rx_gaps = 1'b1;

      write_reg(aae_pkg::REG_ALPHABET, 14'd0);
      write_reg(aae_pkg::REG_ORDER, 14'd0);
      write_reg(aae_pkg::REG_LIMIT, 14'd5);
      random_items(50);

      write_reg(aae_pkg::REG_ALPHABET, 14'd16);
      write_reg(aae_pkg::REG_ORDER, 14'd2);
      write_reg(aae_pkg::REG_LIMIT, 14'd0);
      random_items(50);
      send_item(aae_pkg::KIND_FLUSH, 4'd0);

      drain();
      if (sb.waiting() != 0) report_mismatch(" expected results left over");
      $display("covered %0d items over six register settings, %0d code bits checked",
               items_sent, bits_seen);
      $display("including flushes, restarts, bad symbols, unused kind and output stalls");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* adaptive_arith_encoder_order_n.f */
+incdir+rtl
rtl/aae_pkg.sv
rtl/aae_div.sv
rtl/adaptive_arith_encoder_order_n.sv
tb/tb_adaptive_arith_encoder_order_n.sv
